/* rtl/cpcp_pkg.sv */
package cpcp_pkg;

    // datapath word and field widths
    localparam int DW          = 32;
    localparam int RB_W        = 13;
    localparam int RENDER_W    = 16;
    localparam int OP_W        = 2;
    localparam int RATE_CODE_W = 3;
    localparam int CFG_IDX_W   = 1;

    // divider: quotient bits retired per cycle (must divide DW)
    localparam int DIV_BITS_DEFAULT = 2;

    localparam logic [DW-1:0]       CLOCK_DIVISOR = 32'd25;
    localparam logic [DW-1:0]       BOUND_NUM     = 32'h0100_0000;
    localparam logic [DW-1:0]       RENDER_CAP    = 32'd44100;
    localparam logic [DW-1:0]       CPU_CLOCK_RST = 32'd19660800;
    localparam logic [RATE_CODE_W-1:0] RATE_CODE_RST = 3'd2;

    // input op codes
    localparam logic [OP_W-1:0] OP_SETUP = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET = 2'd1;
    localparam logic [OP_W-1:0] OP_SYNC  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_CLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CODE = 1'b1;

    // microprogram counter width
    localparam int UPC_W = 5;

    typedef enum logic [4:0] {
        U_IDLE,
        U_NOP,
        U_CLEAR,
        U_MARK,
        U_DIV_CLK,
        U_LD_CLK,
        U_DIV_BOUND,
        U_LD_BOUND,
        U_HALVE,
        U_DIV_GAP,
        U_LD_SETUP,
        U_GAP,
        U_MUL_GAP,
        U_DIV_DUE,
        U_LD_DUE,
        U_MUL_DUE,
        U_DIV_ADV,
        U_ADVANCE,
        U_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_ACCEPT,
        C_IS_SETUP,
        C_IS_SYNC,
        C_DIV_BUSY,
        C_BOUND_OK,
        C_SKIP_SYNC,
        C_DUE_ZERO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t             uop;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic accept;
        logic is_setup;
        logic is_sync;
        logic div_busy;
        logic bound_ok;
        logic skip_sync;
        logic due_zero;
        logic out_busy;
    } flags_t;

    // sample rate / 25 for each rate code
    function automatic logic [RB_W-1:0] rate_hz_base(input logic [RATE_CODE_W-1:0] code);
        logic [RB_W-1:0] v;
        begin
            case (code)
                3'd0:    v = 13'd441;
                3'd1:    v = 13'd882;
                3'd2:    v = 13'd1764;
                3'd3:    v = 13'd1920;
                3'd4:    v = 13'd3528;
                3'd5:    v = 13'd3840;
                3'd6:    v = 13'd7056;
                3'd7:    v = 13'd7680;
                default: v = 13'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/cpcp_div.sv */
module cpcp_div
    import cpcp_pkg::*;
#(
    parameter int BITS_PER_CYCLE = DIV_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int STEPS = DW / BITS_PER_CYCLE;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dvs_reg, dvs_next;

    logic [DW-1:0]    rem_step;
    logic [DW-1:0]    quo_step;
    logic [DW:0]      trial;

    // restoring division, BITS_PER_CYCLE quotient bits per cycle
    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        for (int k = 0; k < BITS_PER_CYCLE; k++)
        begin
            trial = {rem_step, quo_step[DW-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial    = trial - {1'b0, dvs_reg};
                quo_step = {quo_step[DW-2:0], 1'b1};
            end
            else
            begin
                quo_step = {quo_step[DW-2:0], 1'b0};
            end
            rem_step = trial[DW-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = quo_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/cpcp_useq.sv */
module cpcp_useq
    import cpcp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctl_t   ctl
);

    // step addresses
    localparam logic [UPC_W-1:0] S_IDLE     = 5'd0;
    localparam logic [UPC_W-1:0] S_SETUP    = 5'd4;
    localparam logic [UPC_W-1:0] S_CLK_WAIT = 5'd5;
    localparam logic [UPC_W-1:0] S_BND_WAIT = 5'd8;
    localparam logic [UPC_W-1:0] S_LOOP     = 5'd10;
    localparam logic [UPC_W-1:0] S_MIN_DIV  = 5'd12;
    localparam logic [UPC_W-1:0] S_MIN_WAIT = 5'd13;
    localparam logic [UPC_W-1:0] S_SYNC     = 5'd15;
    localparam logic [UPC_W-1:0] S_DUE_WAIT = 5'd19;
    localparam logic [UPC_W-1:0] S_ADV_WAIT = 5'd24;
    localparam logic [UPC_W-1:0] S_EMIT     = 5'd26;

    function automatic ctl_t rom(input logic [UPC_W-1:0] pc);
        ctl_t w;
        begin
            w = '{uop: U_NOP, cond: C_ALWAYS, target: S_IDLE};
            case (pc)
                5'd0:  w = '{uop: U_IDLE,      cond: C_NO_ACCEPT, target: S_IDLE};
                5'd1:  w = '{uop: U_CLEAR,     cond: C_IS_SETUP,  target: S_SETUP};
                5'd2:  w = '{uop: U_NOP,       cond: C_IS_SYNC,   target: S_SYNC};
                5'd3:  w = '{uop: U_MARK,      cond: C_ALWAYS,    target: S_EMIT};
                // setup
                5'd4:  w = '{uop: U_DIV_CLK,   cond: C_NO_ACCEPT, target: S_CLK_WAIT};
                5'd5:  w = '{uop: U_NOP,       cond: C_DIV_BUSY,  target: S_CLK_WAIT};
                5'd6:  w = '{uop: U_LD_CLK,    cond: C_NO_ACCEPT, target: S_IDLE};
                5'd7:  w = '{uop: U_DIV_BOUND, cond: C_NO_ACCEPT, target: S_IDLE};
                5'd8:  w = '{uop: U_NOP,       cond: C_DIV_BUSY,  target: S_BND_WAIT};
                5'd9:  w = '{uop: U_LD_BOUND,  cond: C_NO_ACCEPT, target: S_IDLE};
                5'd10: w = '{uop: U_NOP,       cond: C_BOUND_OK,  target: S_MIN_DIV};
                5'd11: w = '{uop: U_HALVE,     cond: C_ALWAYS,    target: S_LOOP};
                5'd12: w = '{uop: U_DIV_GAP,   cond: C_NO_ACCEPT, target: S_IDLE};
                5'd13: w = '{uop: U_NOP,       cond: C_DIV_BUSY,  target: S_MIN_WAIT};
                5'd14: w = '{uop: U_LD_SETUP,  cond: C_ALWAYS,    target: S_EMIT};
                // sync
                5'd15: w = '{uop: U_GAP,       cond: C_NO_ACCEPT, target: S_IDLE};
                5'd16: w = '{uop: U_NOP,       cond: C_SKIP_SYNC, target: S_EMIT};
                5'd17: w = '{uop: U_MUL_GAP,   cond: C_NO_ACCEPT, target: S_IDLE};
                5'd18: w = '{uop: U_DIV_DUE,   cond: C_NO_ACCEPT, target: S_IDLE};
                5'd19: w = '{uop: U_NOP,       cond: C_DIV_BUSY,  target: S_DUE_WAIT};
                5'd20: w = '{uop: U_LD_DUE,    cond: C_NO_ACCEPT, target: S_IDLE};
                5'd21: w = '{uop: U_NOP,       cond: C_DUE_ZERO,  target: S_EMIT};
                5'd22: w = '{uop: U_MUL_DUE,   cond: C_NO_ACCEPT, target: S_IDLE};
                5'd23: w = '{uop: U_DIV_ADV,   cond: C_NO_ACCEPT, target: S_IDLE};
                5'd24: w = '{uop: U_NOP,       cond: C_DIV_BUSY,  target: S_ADV_WAIT};
                5'd25: w = '{uop: U_ADVANCE,   cond: C_NO_ACCEPT, target: S_IDLE};
                // result
                5'd26: w = '{uop: U_EMIT,      cond: C_OUT_BUSY,  target: S_EMIT};
                5'd27: w = '{uop: U_NOP,       cond: C_ALWAYS,    target: S_IDLE};
                default: w = '{uop: U_NOP,     cond: C_ALWAYS,    target: S_IDLE};
            endcase
            return w;
        end
    endfunction

    logic [UPC_W-1:0] pc_reg, pc_next;
    ctl_t             word;
    logic             take;

    // outside the idle step, no input is accepted, so C_NO_ACCEPT loops back
    // at the idle step only while accept is low; it is used as the plain
    // fall-through condition elsewhere since in_stall is high off idle.
    always_comb
    begin
        word = rom(pc_reg);
        case (word.cond)
            C_ALWAYS:    take = 1'b1;
            C_NO_ACCEPT: take = (pc_reg == S_IDLE) && !flags.accept;
            C_IS_SETUP:  take = flags.is_setup;
            C_IS_SYNC:   take = flags.is_sync;
            C_DIV_BUSY:  take = flags.div_busy;
            C_BOUND_OK:  take = flags.bound_ok;
            C_SKIP_SYNC: take = flags.skip_sync;
            C_DUE_ZERO:  take = flags.due_zero;
            C_OUT_BUSY:  take = flags.out_busy;
            default:     take = 1'b0;
        endcase
        pc_next = take ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctl = word;

endmodule

/* rtl/cpu_clock_to_sample_pacer_unit.sv */
// CPU clock to sample pacer. Every input word (op, now_clock) yields a result
// word of its own. Setup (op 0) divides cpu_clock_hz and the selected sample
// rate by 25, halves both (rounding up) until the rate base is at most
// 0x0100_0000 / (unhalved clock base >> 8), with no limit when that shift is
// zero, stores the bases and a minimum cycle gap, and marks now_clock as the
// sync point. Reset point (op 1) only re-marks the sync point; op 3 does
// nothing. Sync (op 2) turns the cycles since the sync point into samples
// (32-bit wrapping math), advances the sync point by the whole cycles those
// samples cover, and reports samples_due, samples_rendered (capped at 44100)
// and advanced; other ops give zeros. One word is in flight at a time:
// in_stall is high from acceptance until just after the result is loaded
// into the output register, which may still be waiting on out_stall when
// the next word is taken. Timing is set by one shared iterative divider that
// retires DIV_RADIX_BITS quotient bits per cycle and a microcoded step
// sequencer. Configuration must be written only while the block is idle.
module cpu_clock_to_sample_pacer_unit
    import cpcp_pkg::*;
#(
    parameter int DIV_RADIX_BITS = DIV_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DW-1:0]        cfg_data,
    // input words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      op,
    input  logic [DW-1:0]        now_clock,
    // result words
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DW-1:0]        samples_due,
    output logic [RENDER_W-1:0]  samples_rendered,
    output logic                 advanced
);

    // config registers
    logic [DW-1:0]          cpu_clock_hz_reg, cpu_clock_hz_next;
    logic [RATE_CODE_W-1:0] rate_code_reg, rate_code_next;

    // architectural state
    logic [DW-1:0]   last_sync_reg, last_sync_next;
    logic [RB_W-1:0] rate_base_reg, rate_base_next;
    logic [DW-1:0]   clock_base_reg, clock_base_next;
    logic [DW-1:0]   min_gap_reg, min_gap_next;

    // working registers
    logic [OP_W-1:0] op_reg, op_next;
    logic [DW-1:0]   now_reg, now_next;
    logic [DW-1:0]   clk_reg, clk_next;
    logic [RB_W-1:0] hz_reg, hz_next;
    logic [DW-1:0]   bound_reg, bound_next;
    logic [DW-1:0]   gap_reg, gap_next;
    logic [DW-1:0]   prod_reg, prod_next;
    logic [DW-1:0]   due_reg, due_next;
    logic            moved_reg, moved_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [DW-1:0]       out_due_reg, out_due_next;
    logic [RENDER_W-1:0] out_rend_reg, out_rend_next;
    logic                out_adv_reg, out_adv_next;

    ctl_t          ctl;
    flags_t        flags;
    logic          accept;
    logic          emit_load;
    logic          div_start;
    logic          div_busy;
    logic [DW-1:0] div_a;
    logic [DW-1:0] div_b;
    logic [DW-1:0] quot;
    logic [DW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic [2*DW-1:0] mul_p;
    logic [DW:0]     clk_inc;
    logic [RB_W:0]   hz_inc;

    assign in_stall = (ctl.uop != U_IDLE);
    assign accept   = in_valid && !in_stall;

    cpcp_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    cpcp_div #(
        .BITS_PER_CYCLE (DIV_RADIX_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (quot)
    );

    // condition flags for the sequencer
    always_comb
    begin
        flags.accept    = accept;
        flags.is_setup  = (op_reg == OP_SETUP);
        flags.is_sync   = (op_reg == OP_SYNC);
        flags.div_busy  = div_busy;
        flags.bound_ok  = (bound_reg >= {{(DW-RB_W){1'b0}}, hz_reg});
        flags.skip_sync = (gap_reg < min_gap_reg) || (clock_base_reg == '0)
                          || (rate_base_reg == '0);
        flags.due_zero  = (due_reg == '0);
        flags.out_busy  = out_valid_reg && out_stall;
    end

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        case (ctl.uop)
            U_DIV_CLK:
            begin
                div_start = 1'b1;
                div_a     = cpu_clock_hz_reg;
                div_b     = CLOCK_DIVISOR;
            end
            U_DIV_BOUND:
            begin
                div_start = 1'b1;
                div_a     = BOUND_NUM;
                div_b     = {8'd0, clk_reg[DW-1:8]};
            end
            U_DIV_GAP:
            begin
                div_start = 1'b1;
                div_a     = {clk_reg[DW-2:0], 1'b0};
                div_b     = {{(DW-RB_W){1'b0}}, hz_reg};
            end
            U_DIV_DUE:
            begin
                div_start = 1'b1;
                div_a     = prod_reg;
                div_b     = clock_base_reg;
            end
            U_DIV_ADV:
            begin
                div_start = 1'b1;
                div_a     = prod_reg;
                div_b     = {{(DW-RB_W){1'b0}}, rate_base_reg};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // single shared multiplier, low word used
    assign mul_a = (ctl.uop == U_MUL_DUE) ? due_reg : gap_reg;
    assign mul_b = (ctl.uop == U_MUL_DUE) ? clock_base_reg
                                          : {{(DW-RB_W){1'b0}}, rate_base_reg};
    assign mul_p = mul_a * mul_b;

    // round-up halving
    assign clk_inc = {1'b0, clk_reg} + {{DW{1'b0}}, 1'b1};
    assign hz_inc  = {1'b0, hz_reg} + {{RB_W{1'b0}}, 1'b1};

    assign emit_load = (ctl.uop == U_EMIT) && !flags.out_busy;

    // datapath
    always_comb
    begin
        cpu_clock_hz_next = cpu_clock_hz_reg;
        rate_code_next    = rate_code_reg;
        last_sync_next    = last_sync_reg;
        rate_base_next    = rate_base_reg;
        clock_base_next   = clock_base_reg;
        min_gap_next      = min_gap_reg;
        op_next           = op_reg;
        now_next          = now_reg;
        clk_next          = clk_reg;
        hz_next           = hz_reg;
        bound_next        = bound_reg;
        gap_next          = gap_reg;
        prod_next         = prod_reg;
        due_next          = due_reg;
        moved_next        = moved_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CPU_CLOCK: cpu_clock_hz_next = cfg_data;
                CFG_RATE_CODE: rate_code_next    = cfg_data[RATE_CODE_W-1:0];
                default:       cpu_clock_hz_next = cpu_clock_hz_reg;
            endcase
        end

        if (accept)
        begin
            op_next  = op;
            now_next = now_clock;
        end

        case (ctl.uop)
            U_CLEAR:
            begin
                due_next   = '0;
                moved_next = 1'b0;
            end
            U_MARK:
            begin
                if (op_reg == OP_RESET)
                begin
                    last_sync_next = now_reg;
                end
            end
            U_LD_CLK:
            begin
                clk_next = quot;
                hz_next  = rate_hz_base(rate_code_reg);
            end
            U_LD_BOUND:
            begin
                // tiny clock: bound saturates
                bound_next = (clk_reg[DW-1:8] == '0) ? '1 : quot;
            end
            U_HALVE:
            begin
                clk_next = clk_inc[DW:1];
                hz_next  = hz_inc[RB_W:1];
            end
            U_LD_SETUP:
            begin
                rate_base_next  = hz_reg;
                clock_base_next = clk_reg;
                min_gap_next    = (hz_reg == '0) ? '0 : quot;
                last_sync_next  = now_reg;
            end
            U_GAP:
            begin
                gap_next = now_reg - last_sync_reg;
            end
            U_MUL_GAP, U_MUL_DUE:
            begin
                prod_next = mul_p[DW-1:0];
            end
            U_LD_DUE:
            begin
                due_next = quot;
            end
            U_ADVANCE:
            begin
                last_sync_next = last_sync_reg + quot;
                moved_next     = 1'b1;
            end
            default:
            begin
                moved_next = moved_reg;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_due_next   = out_due_reg;
        out_rend_next  = out_rend_reg;
        out_adv_next   = out_adv_reg;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
            out_due_next   = due_reg;
            out_rend_next  = (due_reg < RENDER_CAP) ? due_reg[RENDER_W-1:0]
                                                    : RENDER_CAP[RENDER_W-1:0];
            out_adv_next   = moved_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_clock_hz_reg <= CPU_CLOCK_RST;
            rate_code_reg    <= RATE_CODE_RST;
            last_sync_reg    <= '0;
            rate_base_reg    <= '0;
            clock_base_reg   <= '0;
            min_gap_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cpu_clock_hz_reg <= cpu_clock_hz_next;
            rate_code_reg    <= rate_code_next;
            last_sync_reg    <= last_sync_next;
            rate_base_reg    <= rate_base_next;
            clock_base_reg   <= clock_base_next;
            min_gap_reg      <= min_gap_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        clk_reg      <= clk_next;
        hz_reg       <= hz_next;
        bound_reg    <= bound_next;
        gap_reg      <= gap_next;
        prod_reg     <= prod_next;
        due_reg      <= due_next;
        moved_reg    <= moved_next;
        out_due_reg  <= out_due_next;
        out_rend_reg <= out_rend_next;
        out_adv_reg  <= out_adv_next;
    end

    assign out_valid        = out_valid_reg;
    assign samples_due      = out_due_reg;
    assign samples_rendered = out_rend_reg;
    assign advanced         = out_adv_reg;

    // never restart the divider mid-operation
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // the sync point moves only on a nonzero sample count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_adv_reg |-> out_due_reg != '0)
        else $error("advance reported with zero samples");

    // rendered count is the capped due count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rend_reg == out_due_reg[RENDER_W-1:0]
                           || out_rend_reg == RENDER_CAP[RENDER_W-1:0]))
        else $error("rendered count not derived from due count");

    // a result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> !(out_valid_reg && out_stall))
        else $error("result overwrote a stalled word");

endmodule

/* dv/cpu_clock_to_sample_pacer_unit_tb.sv */
module cpu_clock_to_sample_pacer_unit_tb;
    import cpcp_pkg::*;

    // Op code 3 has no name in the package; the block must ignore it.
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    // Generous cycle budget: ~1750 words, each with its worst-case busy time,
    // a random feed gap and a random output hold.
    localparam int RUN_LIMIT = 1_500_000;
    localparam int PHASE_WORDS = 190;
    localparam int PHASE_COUNT = 9;

    // One result word as the block reports it.
    typedef struct packed {
        logic [DW-1:0]       due;
        logic [RENDER_W-1:0] rend;
        logic                adv;
    } pacer_result_t;

    localparam pacer_result_t ZERO_RESULT = '0;

    // Directed table: either a word to send or a pair of rate settings.
    typedef enum logic {ROW_WORD, ROW_RATES} row_kind_e;

    typedef struct packed {
        row_kind_e       kind;
        logic [OP_W-1:0] w_op;
        logic [DW-1:0]   value;     // now_clock, or cpu_clock_hz for ROW_RATES
        logic [2:0]      code;      // sample rate code for ROW_RATES
        logic            pinned;    // result typed in below, not computed
        pacer_result_t   pin;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DW-1:0]        cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      op = '0;
    logic [DW-1:0]        now_clock = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [DW-1:0]        samples_due;
    logic [RENDER_W-1:0]  samples_rendered;
    logic                 advanced;

    cpu_clock_to_sample_pacer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .now_clock        (now_clock),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .samples_due      (samples_due),
        .samples_rendered (samples_rendered),
        .advanced         (advanced)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Pacer state mirror: registers plus what setup and sync leave behind
    // ------------------------------------------------------------------
    logic [DW-1:0]   cpu_hz_r    = CPU_CLOCK_RST;
    logic [2:0]      rate_code_r = RATE_CODE_RST;
    logic [DW-1:0]   sync_mark   = '0;
    logic [RB_W-1:0] rate_base_r = '0;
    logic [DW-1:0]   clock_base_r = '0;
    logic [DW-1:0]   min_gap_r   = '0;

    pacer_result_t samples_owed_q[$];   // results still owed by the block, oldest first
    stim_row_t     stim_rows[$];
    logic [DW-1:0] now_cursor = '0;

    int feed_gap_pct  = 10;   // chance per word that the sender sits idle first
    int sink_hold_pct = 2;    // chance per cycle that the receiver starts a hold
    int hold_left     = 0;

    int cycle_count    = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int advanced_seen  = 0;
    int capped_seen    = 0;
    int settings_done  = 0;
    int mismatches     = 0;

    function automatic logic [DW-1:0] sample_rate_hz(input logic [2:0] code);
        case (code)
            3'd0:    return 32'd11025;
            3'd1:    return 32'd22050;
            3'd2:    return 32'd44100;
            3'd3:    return 32'd48000;
            3'd4:    return 32'd88200;
            3'd5:    return 32'd96000;
            3'd6:    return 32'd176400;
            default: return 32'd192000;
        endcase
    endfunction

    // Apply one word to the mirrored state and return the result it owes.
    function automatic pacer_result_t pace_word(input logic [OP_W-1:0] w_op,
                                                input logic [DW-1:0] w_now);
        pacer_result_t res;
        logic [DW-1:0] c_base;
        logic [DW-1:0] hz;
        logic [DW-1:0] bound;
        logic [DW-1:0] rb32;
        logic [DW-1:0] gap;
        logic [DW-1:0] prod;
        logic [DW-1:0] due;
        res = ZERO_RESULT;
        case (w_op)
            OP_SETUP: begin
                c_base = cpu_hz_r / CLOCK_DIVISOR;
                hz     = sample_rate_hz(rate_code_r) / CLOCK_DIVISOR;
                // tiny clock: shifted base is zero, bound saturates, no halving
                bound  = ((c_base >> 8) != 0) ? BOUND_NUM / (c_base >> 8) : '1;
                while (bound < hz) begin
                    c_base = (c_base + 32'd1) >> 1;
                    hz     = (hz + 32'd1) >> 1;
                end
                rate_base_r  = hz[RB_W-1:0];
                clock_base_r = c_base;
                rb32         = {{(DW-RB_W){1'b0}}, rate_base_r};
                min_gap_r    = (rb32 != 0) ? (c_base << 1) / rb32 : '0;
                sync_mark    = w_now;
            end
            OP_RESET: sync_mark = w_now;
            OP_SYNC: begin
                rb32 = {{(DW-RB_W){1'b0}}, rate_base_r};
                gap  = w_now - sync_mark;
                if (gap >= min_gap_r && clock_base_r != 0 && rb32 != 0) begin
                    prod = gap * rb32;              // wraps at 32 bits
                    due  = prod / clock_base_r;
                    if (due != 0) begin
                        prod      = due * clock_base_r;
                        sync_mark = sync_mark + prod / rb32;
                        res.adv   = 1'b1;
                    end
                    res.due  = due;
                    res.rend = (due < RENDER_CAP) ? due[RENDER_W-1:0]
                                                  : RENDER_CAP[RENDER_W-1:0];
                end
            end
            default: ;   // op 3: nothing moves
        endcase
        return res;
    endfunction

    // Next now_clock for a random word. Mostly walks forward from the last
    // value; some land right on the minimum-gap edge, some jump anywhere.
    function automatic logic [DW-1:0] pick_now();
        int sel;
        logic [DW-1:0] t;
        sel = $urandom_range(99);
        if (sel < 8)
            t = $urandom();
        else if (sel < 20)
            t = sync_mark + min_gap_r + $urandom_range(2) - 1;
        else if (sel < 50)
            t = now_cursor + $urandom_range(min_gap_r * 4 + 16);
        else if (sel < 85)
            t = now_cursor + $urandom_range(32'h000F_FFFF);
        else
            t = now_cursor + $urandom_range(32'h3FFF_FFFF);
        now_cursor = t;
        return t;
    endfunction

    function automatic void add_row(input row_kind_e kind, input logic [OP_W-1:0] w_op,
                                    input logic [DW-1:0] value, input logic [2:0] code,
                                    input logic pinned, input pacer_result_t pin);
        stim_row_t r;
        r.kind   = kind;
        r.w_op   = w_op;
        r.value  = value;
        r.code   = code;
        r.pinned = pinned;
        r.pin    = pin;
        stim_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one word and hold it until taken. The owed result is worked
    // out at the accepting edge so the mirror tracks the block in order.
    task automatic send_word(input logic [OP_W-1:0] w_op, input logic [DW-1:0] w_now,
                             input logic pinned, input pacer_result_t pin);
        pacer_result_t res;
        if ($urandom_range(99) < feed_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(80, 1)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= w_op;
        now_clock <= w_now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        res = pace_word(w_op, w_now);
        samples_owed_q.push_back(pinned ? pin : res);
        words_sent++;
    endtask

    // Sender holds off until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (samples_owed_q.size() != 0) @(posedge clk);
    endtask

    // Both registers, back to back; only called with the block idle.
    task automatic write_rates(input logic [DW-1:0] cpu_hz, input logic [DW-1:0] code_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CPU_CLOCK;
        cfg_data  <= cpu_hz;
        @(posedge clk);
        cfg_index <= CFG_RATE_CODE;
        cfg_data  <= code_word;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cpu_hz_r    = cpu_hz;
        rate_code_r = code_word[2:0];
        settings_done++;
    endtask

    // One random phase: new rates, a setup, then mostly syncs.
    task automatic run_phase(input int idx);
        logic [DW-1:0]   cpu_hz;
        logic [2:0]      code;
        logic [OP_W-1:0] w_op;
        int              sel;
        int              n;
        case (idx)
            0:       begin cpu_hz = 32'd1_000_000;  code = 3'd0; end
            1:       begin cpu_hz = 32'hFFFF_FFFF;  code = 3'd7; end
            2:       begin cpu_hz = $urandom_range(32'hFFFF_FFFF, 32'd1_000_000); code = 3'd3; end
            3:       begin cpu_hz = CPU_CLOCK_RST;  code = RATE_CODE_RST; end
            4:       begin cpu_hz = $urandom_range(6399); code = 3'($urandom_range(7)); end
            5:       begin cpu_hz = $urandom();     code = 3'd5; end
            6:       begin cpu_hz = $urandom_range(32'hFFFF_FFFF, 32'd1_000_000); code = 3'd1; end
            7:       begin cpu_hz = $urandom_range(32'h0400_0000, 32'd1_000_000); code = 3'd6; end
            default: begin cpu_hz = $urandom();     code = 3'd4; end
        endcase
        drain_results();
        // phase 2 runs flat out on both sides
        feed_gap_pct  = (idx == 2) ? 0 : 10;
        sink_hold_pct = (idx == 2) ? 0 : 2;
        // upper bits of the rate code write are don't-care; randomize them
        write_rates(cpu_hz, ($urandom() & 32'hFFFF_FFF8) | {29'd0, code});
        now_cursor = $urandom();
        send_word(OP_SETUP, now_cursor, 1'b0, ZERO_RESULT);
        for (n = 1; n < PHASE_WORDS; n++) begin
            sel = $urandom_range(99);
            if (sel < 4)
                w_op = OP_SETUP;
            else if (sel < 9)
                w_op = OP_RESET;
            else if (sel < 12)
                w_op = OP_IGNORED;
            else
                w_op = OP_SYNC;
            send_word(w_op, pick_now(), 1'b0, ZERO_RESULT);
        end
    endtask

    // Receiver: random holds of out_stall, none during the flat-out phase.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if ($urandom_range(99) < sink_hold_pct) begin
            hold_left <= $urandom_range(8);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every taken result against the oldest owed one
    // ------------------------------------------------------------------
    pacer_result_t owed;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (advanced) advanced_seen++;
            if (samples_rendered == RENDER_CAP[RENDER_W-1:0]) capped_seen++;
            if (samples_owed_q.size() == 0) begin
                $display("%0t: result with nothing owed: due %0d rendered %0d advanced %0b",
                         $time, samples_due, samples_rendered, advanced);
                mismatches++;
            end else begin
                owed = samples_owed_q.pop_front();
                if (samples_due !== owed.due) begin
                    $display("%0t: samples_due expected %0d got %0d",
                             $time, owed.due, samples_due);
                    mismatches++;
                end
                if (samples_rendered !== owed.rend) begin
                    $display("%0t: samples_rendered expected %0d got %0d",
                             $time, owed.rend, samples_rendered);
                    mismatches++;
                end
                if (advanced !== owed.adv) begin
                    $display("%0t: advanced expected %0b got %0b",
                             $time, owed.adv, advanced);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("cpu_clock_to_sample_pacer_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random phases
    // ------------------------------------------------------------------
    initial begin : stimulus
        int i;
        int p;

        // Reset-value rates: 19660800 Hz, 44100 Hz. Bases come out as
        // 786432 and 1764 with no halving, so the minimum gap is 891.
        add_row(ROW_WORD,  OP_SYNC,    32'd1000,     3'd0, 1'b1, ZERO_RESULT); // sync before setup
        add_row(ROW_WORD,  OP_IGNORED, 32'hFFFF_FFFF, 3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_RESET,   32'd0,        3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SETUP,   32'd0,        3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'd0,        3'd0, 1'b1, ZERO_RESULT); // zero gap
        add_row(ROW_WORD,  OP_SYNC,    32'd890,      3'd0, 1'b1, ZERO_RESULT); // one short
        add_row(ROW_WORD,  OP_SYNC,    32'd891,      3'd0, 1'b0, ZERO_RESULT); // exactly min
        add_row(ROW_WORD,  OP_SYNC,    32'hFFFF_FFFF, 3'd0, 1'b0, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'h8000_0000, 3'd0, 1'b0, ZERO_RESULT); // product wraps
        add_row(ROW_WORD,  OP_RESET,   32'hFFFF_FFF0, 3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'h0000_1000, 3'd0, 1'b0, ZERO_RESULT); // across zero
        add_row(ROW_WORD,  OP_IGNORED, 32'd0,        3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'h1234_5678, 3'd0, 1'b0, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SETUP,   32'hFFFF_FFFF, 3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'hFFFF_FFFF, 3'd0, 1'b1, ZERO_RESULT);
        // Slowest legal clock, fastest rate: the gap below yields well over
        // the render cap.
        add_row(ROW_RATES, OP_SETUP,   32'd1_000_000, 3'd7, 1'b0, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SETUP,   32'd100,      3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'd559_340,  3'd0, 1'b0, ZERO_RESULT);
        // Fastest clock, slowest rate: several halving rounds.
        add_row(ROW_RATES, OP_SETUP,   32'hFFFF_FFFF, 3'd0, 1'b0, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SETUP,   32'd5,        3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'h0100_0005, 3'd0, 1'b0, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'hFFFF_FFFF, 3'd0, 1'b0, ZERO_RESULT);
        // Tiny clock: bound saturates, minimum gap is zero.
        add_row(ROW_RATES, OP_SETUP,   32'd5000,     3'd3, 1'b0, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SETUP,   32'd77,       3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'd77,       3'd0, 1'b0, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'd78,       3'd0, 1'b0, ZERO_RESULT);
        // Clock below the divisor: clock base is zero, syncs give nothing.
        add_row(ROW_RATES, OP_SETUP,   32'd10,       3'd5, 1'b0, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SETUP,   32'd0,        3'd0, 1'b1, ZERO_RESULT);
        add_row(ROW_WORD,  OP_SYNC,    32'hFFFF_FFFF, 3'd0, 1'b1, ZERO_RESULT);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < stim_rows.size(); i++) begin
            if (stim_rows[i].kind == ROW_RATES) begin
                drain_results();
                write_rates(stim_rows[i].value, {29'd0, stim_rows[i].code});
            end else begin
                send_word(stim_rows[i].w_op, stim_rows[i].value,
                          stim_rows[i].pinned, stim_rows[i].pin);
            end
        end

        for (p = 0; p < PHASE_COUNT; p++) run_phase(p);

        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d words over %0d rate settings; %0d results checked.",
                 words_sent, settings_done, results_seen);
        $display("%0d syncs moved the sync point, %0d hit the render cap, %0d mismatches.",
                 advanced_seen, capped_seen, mismatches);
        if (mismatches == 0 && samples_owed_q.size() == 0)
            $display("cpu_clock_to_sample_pacer_unit verification clean");
        else
            $display("cpu_clock_to_sample_pacer_unit verification failed");
        $finish;
    end

endmodule
